[rtl/core/multi_token_bucket_table_macros.svh]
// ----------------------------------------------------------------------------
// multi token bucket table assertion macros
// shared immediate-implication and next-cycle checks, clocked on clk with
// the synchronous active-low reset masking them
// ----------------------------------------------------------------------------
`ifndef MULTI_TOKEN_BUCKET_TABLE_MACROS_SVH
`define MULTI_TOKEN_BUCKET_TABLE_MACROS_SVH

// same-cycle implication
`define MTBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MTBT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/mtbt_pkg.sv]
// ----------------------------------------------------------------------------
// mtbt_pkg
// request and result types, command and status codes of the token bucket table
// ----------------------------------------------------------------------------
package mtbt_pkg;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  bucket;
    logic [15:0] rate;
    logic [15:0] burst_limit;
    logic [15:0] request;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [15:0] granted;
  } out_t;

  localparam logic [2:0] CMD_CREATE      = 3'd0;
  localparam logic [2:0] CMD_TICK        = 3'd1;
  localparam logic [2:0] CMD_FETCH       = 3'd2;
  localparam logic [2:0] CMD_DESTROY     = 3'd3;
  localparam logic [2:0] CMD_DESTROY_ALL = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

endpackage

[rtl/core/mtbt_alu.sv]
// ----------------------------------------------------------------------------
// mtbt_alu
// shared token arithmetic: refill with saturation at the ceiling, or
// grant the lesser of request and tokens and return what is left
// ----------------------------------------------------------------------------
module mtbt_alu #(
  parameter int TOKEN_BITS = 16
) (
  input  mtbt_pkg::alu_op_t        op,
  input  logic [TOKEN_BITS-1:0]    tok,
  input  logic [TOKEN_BITS-1:0]    addend,
  input  logic [TOKEN_BITS-1:0]    lim,
  input  logic [15:0]              request,
  output logic [TOKEN_BITS-1:0]    res,
  output logic [15:0]              grant
);

  localparam int AW = ((TOKEN_BITS > 16) ? TOKEN_BITS : 16) + 1;

  logic          is_sub;
  logic [AW-1:0] opb;
  logic [AW-1:0] sum;
  logic          neg;
  logic          sat;

  assign is_sub = (op == mtbt_pkg::ALU_SUB);
  assign opb    = is_sub ? AW'(request) : AW'(addend);
  // single adder, subtract by inverting b with carry in
  assign sum    = AW'(tok) + (is_sub ? ~opb : opb) + AW'(is_sub);
  assign neg    = sum[AW-1];
  assign sat    = (sum >= AW'(lim));

  always_comb begin
    if (is_sub) begin
      if (neg) begin
        res   = '0;
        grant = 16'(tok);
      end else begin
        res   = TOKEN_BITS'(sum);
        grant = request;
      end
    end else begin
      res   = sat ? lim : TOKEN_BITS'(sum);
      grant = '0;
    end
  end

endmodule

[rtl/core/multi_token_bucket_table.sv]
// ----------------------------------------------------------------------------
// multi_token_bucket_table
// table of NUM_BUCKETS token buckets driven by create, tick, fetch and
// destroy commands, one result per request
// ----------------------------------------------------------------------------
// Usage: drive in_data and raise start; the request is taken at an edge where
// start is high and busy is low. Exactly one result follows on out_data,
// marked by a one-cycle out_valid strobe; it must be taken that cycle, the
// receiver has no way to stall it. busy is low again in the strobe cycle, so
// the next request may be issued there.
// Path from the accepting request to its result: destroy, destroy-all,
// unknown commands and rejected fetches answer straight from idle; fetch
// reads the table, then makes one pass through the shared adder; create
// runs the free-slot scan at one slot per cycle; tick steps one slot per
// cycle through the table read port and the shared adder, then a drain state
// does the last write back. A new request is taken only once the last result
// is out, so back-to-back ticks each wait for the whole table pass.
// Reset (synchronous, active low) marks every slot free and idles the
// sequencer; the bucket table itself needs no clearing since a slot's contents
// are only used after create has written it.
// ----------------------------------------------------------------------------
`include "multi_token_bucket_table_macros.svh"

module multi_token_bucket_table #(
  parameter int NUM_BUCKETS = 8,
  parameter int TOKEN_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mtbt_pkg::in_t   in_data,
  output logic            busy,
  output logic            out_valid,
  output mtbt_pkg::out_t  out_data
);

  localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CREATE   = 3'd1;
  localparam logic [2:0] S_TICK     = 3'd2;
  localparam logic [2:0] S_DRAIN    = 3'd3;
  localparam logic [2:0] S_FETCH    = 3'd4;
  localparam logic [2:0] S_FETCH_WR = 3'd5;

  typedef struct packed {
    logic [TOKEN_BITS-1:0] tokens;
    logic [TOKEN_BITS-1:0] fill_rate;
    logic [TOKEN_BITS-1:0] ceiling;
  } entry_t;

  logic [2:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       wb_idx_r;
  logic                   wb_vld_r, wb_vld_nxt;
  logic [NUM_BUCKETS-1:0] in_use_r, in_use_nxt;
  mtbt_pkg::in_t          req_r, req_nxt;
  logic                   out_valid_r, out_valid_nxt;
  mtbt_pkg::out_t         out_r, out_nxt;

  entry_t                 mem [NUM_BUCKETS];
  entry_t                 rd_data_r;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  entry_t                 mem_wdata;

  mtbt_pkg::alu_op_t      alu_op;
  logic [TOKEN_BITS-1:0]  alu_res;
  logic [15:0]            alu_grant;

  logic                   in_acc;
  logic [IDX_W-1:0]       bidx;
  logic                   bucket_ok;
  logic                   bucket_used;

  logic                   in_tick;
  logic                   res_fetch;
  logic                   res_nospace;
  logic                   res_created;
  int                     n_used;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_acc      = start && !busy;
  assign bidx        = IDX_W'({29'd0, in_data.bucket});
  assign bucket_ok   = ({29'd0, in_data.bucket} < 32'(NUM_BUCKETS));
  assign bucket_used = bucket_ok && in_use_r[bidx];

  mtbt_alu #(
    .TOKEN_BITS(TOKEN_BITS)
  ) u_alu (
    .op      (alu_op),
    .tok     (rd_data_r.tokens),
    .addend  (rd_data_r.fill_rate),
    .lim     (rd_data_r.ceiling),
    .request (req_r.request),
    .res     (alu_res),
    .grant   (alu_grant)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_use_nxt    = in_use_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wb_vld_nxt    = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = '{tokens: alu_res, fill_rate: rd_data_r.fill_rate,
                      ceiling: rd_data_r.ceiling};
    alu_op        = mtbt_pkg::ALU_ADD;

    // refill write back trails the tick read by one slot
    if (wb_vld_r) begin
      mem_we    = 1'b1;
      mem_waddr = wb_idx_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_data;
          cnt_nxt = '0;
          unique case (in_data.cmd)
            mtbt_pkg::CMD_CREATE: begin
              state_nxt = S_CREATE;
            end
            mtbt_pkg::CMD_TICK: begin
              state_nxt = S_TICK;
            end
            mtbt_pkg::CMD_FETCH: begin
              if (bucket_used && (in_data.request != '0)) begin
                cnt_nxt   = bidx;
                state_nxt = S_FETCH;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{status: mtbt_pkg::ST_INVALID, slot: '0, granted: '0};
              end
            end
            mtbt_pkg::CMD_DESTROY: begin
              out_valid_nxt = 1'b1;
              if (bucket_ok) begin
                in_use_nxt[bidx] = 1'b0;
                out_nxt = '{status: mtbt_pkg::ST_OK, slot: '0, granted: '0};
              end else begin
                out_nxt = '{status: mtbt_pkg::ST_INVALID, slot: '0, granted: '0};
              end
            end
            mtbt_pkg::CMD_DESTROY_ALL: begin
              in_use_nxt    = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: mtbt_pkg::ST_OK, slot: '0, granted: '0};
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: mtbt_pkg::ST_INVALID, slot: '0, granted: '0};
            end
          endcase
        end
      end
      S_CREATE: begin
        priority if (!in_use_r[cnt_r]) begin
          in_use_nxt[cnt_r] = 1'b1;
          mem_we        = 1'b1;
          mem_wdata     = '{tokens: '0, fill_rate: TOKEN_BITS'(req_r.rate),
                            ceiling: TOKEN_BITS'(req_r.burst_limit)};
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: mtbt_pkg::ST_OK, slot: 3'(cnt_r), granted: '0};
          state_nxt     = S_IDLE;
        end else if (cnt_r == LAST_IDX) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: mtbt_pkg::ST_NOSPACE, slot: '0, granted: '0};
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_TICK: begin
        wb_vld_nxt = in_use_r[cnt_r];
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: mtbt_pkg::ST_OK, slot: '0, granted: '0};
        state_nxt     = S_IDLE;
      end
      S_FETCH: begin
        state_nxt = S_FETCH_WR;
      end
      S_FETCH_WR: begin
        alu_op        = mtbt_pkg::ALU_SUB;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (rd_data_r.tokens == '0) begin
          out_nxt = '{status: mtbt_pkg::ST_EMPTY, slot: '0, granted: '0};
        end else begin
          mem_we  = 1'b1;
          out_nxt = '{status: mtbt_pkg::ST_OK, slot: '0, granted: alu_grant};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      wb_vld_r    <= 1'b0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wb_vld_r    <= wb_vld_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    out_r    <= out_nxt;
    wb_idx_r <= cnt_r;
  end

  // bucket table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[cnt_r];
  end

  assign in_tick     = (state_r == S_TICK) || (state_r == S_DRAIN);
  assign res_fetch   = out_valid_r && (req_r.cmd == mtbt_pkg::CMD_FETCH);
  assign res_nospace = out_valid_r && (out_r.status == mtbt_pkg::ST_NOSPACE);
  assign res_created = out_valid_r && (req_r.cmd == mtbt_pkg::CMD_CREATE) &&
                       (out_r.status == mtbt_pkg::ST_OK);
  assign n_used      = $countones(in_use_r);

  `MTBT_ASSERT_IMP(a_strobe_idle, out_valid_r, state_r == S_IDLE, "strobe while busy")
  `MTBT_ASSERT_IMP(a_wb_in_tick, wb_vld_r, in_tick, "refill write back outside tick")
  `MTBT_ASSERT_IMP(a_nospace_full, res_nospace, &in_use_r, "no space with a free slot")
  `MTBT_ASSERT_IMP(a_grant_le_req, res_fetch, out_r.granted <= req_r.request, "grant over request")
  `MTBT_ASSERT_IMP(a_create_claims, res_created, n_used == ($past(n_used) + 1), "create slot count")
  `MTBT_ASSERT_NXT(a_fetch_wr, state_r == S_FETCH, state_r == S_FETCH_WR, "fetch write back missing")

endmodule

[tb/sv/mtbt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtbt_checker
// watches the request and result channels of the token bucket table, keeps
// its own copy of the bucket table, predicts each result and compares it
// field by field with what the block returns
// ----------------------------------------------------------------------------
module mtbt_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  mtbt_pkg::in_t  in_data,
  input  logic           out_valid,
  input  mtbt_pkg::out_t out_data,
  output int             fail_count,
  output int             pending,
  output int             checked
);
  import mtbt_pkg::*;

  localparam int NB = 8;

  logic        slot_used    [NB];
  logic [15:0] slot_tokens  [NB];
  logic [15:0] slot_rate    [NB];
  logic [15:0] slot_ceiling [NB];

  out_t expected_results [$];
  int   n_fail;
  int   n_checked;

  // applies one request to the local table and returns the result it causes
  function automatic out_t predict_bucket_cmd(in_t r);
    out_t        res;
    logic [16:0] sum;
    logic [15:0] grant;
    bit          found;
    res = '0;
    res.status = ST_OK;
    found = 1'b0;
    case (r.cmd)
      CMD_CREATE: begin
        res.status = ST_NOSPACE;
        for (int i = 0; i < NB; i++) begin
          if (!found && !slot_used[i]) begin
            slot_used[i]    = 1'b1;
            slot_tokens[i]  = '0;
            slot_rate[i]    = r.rate;
            slot_ceiling[i] = r.burst_limit;
            res.status      = ST_OK;
            res.slot        = 3'(i);
            found           = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < NB; i++) begin
          if (slot_used[i]) begin
            sum = {1'b0, slot_tokens[i]} + {1'b0, slot_rate[i]};
            slot_tokens[i] = (sum >= {1'b0, slot_ceiling[i]}) ? slot_ceiling[i] : sum[15:0];
          end
        end
      end
      CMD_FETCH: begin
        if (r.request == '0 || !slot_used[r.bucket]) begin
          res.status = ST_INVALID;
        end else if (slot_tokens[r.bucket] == '0) begin
          res.status = ST_EMPTY;
        end else begin
          grant = (r.request > slot_tokens[r.bucket]) ? slot_tokens[r.bucket] : r.request;
          slot_tokens[r.bucket] = slot_tokens[r.bucket] - grant;
          res.granted = grant;
        end
      end
      CMD_DESTROY: begin
        slot_used[r.bucket] = 1'b0;
      end
      CMD_DESTROY_ALL: begin
        for (int i = 0; i < NB; i++) slot_used[i] = 1'b0;
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        slot_used[i]    = 1'b0;
        slot_tokens[i]  = '0;
        slot_rate[i]    = '0;
        slot_ceiling[i] = '0;
      end
      expected_results.delete();
      n_fail    = 0;
      n_checked = 0;
    end else begin
      // the result of the previous request comes first, a new request may be
      // taken at the same edge
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d slot %0d granted %0d",
                 out_data.status, out_data.slot, out_data.granted);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
            n_fail++;
          end
          if (out_data.slot !== want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want.slot, out_data.slot);
            n_fail++;
          end
          if (out_data.granted !== want.granted) begin
            $error("granted mismatch: expected %0d, actual %0d", want.granted,
                   out_data.granted);
            n_fail++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_bucket_cmd(in_data));
    end
    fail_count <= n_fail;
    pending    <= expected_results.size();
    checked    <= n_checked;
  end

endmodule

[tb/sv/tb_multi_token_bucket_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_token_bucket_table
// drives create, tick, fetch and destroy requests into the token bucket
// table: a directed opening over the corner cases, then weighted random
// traffic with bursts of idle cycles; the checker predicts every result
// ----------------------------------------------------------------------------
module tb_multi_token_bucket_table;
  import mtbt_pkg::*;

  localparam int N_RANDOM    = 450;
  localparam int QUIET_TAIL  = 60;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic start;
  in_t  in_data;
  logic busy;
  logic out_valid;
  out_t out_data;

  int fail_count;
  int pending;
  int checked;
  int cycle_count;
  int n_create, n_tick, n_fetch, n_destroy, n_unknown;
  bit gaps_on;

  multi_token_bucket_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  mtbt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_t mk_req(logic [2:0] cmd, logic [2:0] bucket, logic [15:0] rate,
                                 logic [15:0] burst, logic [15:0] request);
    in_t r;
    r.cmd         = cmd;
    r.bucket      = bucket;
    r.rate        = rate;
    r.burst_limit = burst;
    r.request     = request;
    return r;
  endfunction

  // mostly small values so buckets drain and refill, with extremes mixed in
  function automatic logic [15:0] pick_level(int hi);
    case ($urandom_range(0, 5))
      0:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(1, hi));
    endcase
  endfunction

  function automatic in_t random_request();
    in_t r;
    int  pick;
    // unused fields carry noise
    r = mk_req(3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      r.cmd         = CMD_CREATE;
      r.rate        = pick_level(64);
      r.burst_limit = pick_level(2000);
    end else if (pick < 43) begin
      r.cmd = CMD_TICK;
    end else if (pick < 80) begin
      r.cmd = CMD_FETCH;
      case ($urandom_range(0, 9))
        0:       r.request = '0;
        1:       r.request = 16'($urandom);
        2:       r.request = 16'hFFFF;
        default: r.request = 16'($urandom_range(1, 300));
      endcase
    end else if (pick < 90) begin
      r.cmd = CMD_DESTROY;
    end else if (pick < 93) begin
      r.cmd = CMD_DESTROY_ALL;
    end else begin
      r.cmd = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  task automatic issue_request(input in_t r, input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= r;
    case (r.cmd)
      CMD_CREATE:                   n_create++;
      CMD_TICK:                     n_tick++;
      CMD_FETCH:                    n_fetch++;
      CMD_DESTROY, CMD_DESTROY_ALL: n_destroy++;
      default:                      n_unknown++;
    endcase
    do @(posedge clk); while (busy);
  endtask

  initial begin
    in_t directed [$];
    int  drain;
    start   = 1'b0;
    in_data = '0;
    rst_n   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unused slot, empty bucket, zero request, saturation, full table,
    // free-slot destroy, unknown commands
    directed.push_back(mk_req(CMD_FETCH, 3'd0, 16'h0000, 16'h0000, 16'd5));
    directed.push_back(mk_req(CMD_CREATE, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(mk_req(CMD_FETCH, 3'd0, 16'h0000, 16'h0000, 16'd1));
    directed.push_back(mk_req(CMD_FETCH, 3'd0, 16'hFFFF, 16'hFFFF, 16'd0));
    directed.push_back(mk_req(CMD_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(mk_req(CMD_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(mk_req(CMD_FETCH, 3'd0, 16'h0000, 16'h0000, 16'hFFFF));
    directed.push_back(mk_req(CMD_CREATE, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(mk_req(CMD_CREATE, 3'd0, 16'd10, 16'd25, 16'h0000));
    repeat (3) directed.push_back(mk_req(CMD_TICK, 3'd0, 16'h0, 16'h0, 16'h0));
    directed.push_back(mk_req(CMD_FETCH, 3'd2, 16'h0000, 16'h0000, 16'd100));
    directed.push_back(mk_req(CMD_DESTROY, 3'd5, 16'h0000, 16'h0000, 16'h0000));
    for (int i = 0; i < 5; i++)
      directed.push_back(mk_req(CMD_CREATE, 3'(i), 16'(i + 1), 16'(100 * i + 7), 16'h0));
    directed.push_back(mk_req(CMD_CREATE, 3'd0, 16'd1, 16'd1, 16'h0000));
    directed.push_back(mk_req(CMD_DESTROY, 3'd1, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(mk_req(CMD_CREATE, 3'd0, 16'd3, 16'd9, 16'h0000));
    directed.push_back(mk_req(3'd5, 3'd3, 16'h1234, 16'h5678, 16'h9ABC));
    directed.push_back(mk_req(3'd6, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(mk_req(3'd7, 3'd7, 16'h0000, 16'h0000, 16'h0001));
    directed.push_back(mk_req(CMD_DESTROY_ALL, 3'd0, 16'h0000, 16'h0000, 16'h0000));
    foreach (directed[i]) issue_request(directed[i], 1'b1);

    gaps_on = 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      issue_request(random_request(), gaps_on && (n < N_RANDOM - QUIET_TAIL));
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    drain = 20;
    repeat (drain) @(posedge clk);

    $display("covered %0d requests: %0d create, %0d tick, %0d fetch, %0d destroy, %0d unknown",
             n_create + n_tick + n_fetch + n_destroy + n_unknown, n_create, n_tick, n_fetch,
             n_destroy, n_unknown);
    $display("%0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
